// ----- design/psvd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package psvd_pkg;

    localparam int KEY_W    = 3;
    localparam int SAMPLE_W = 16;
    localparam int THRESH_W = 15;
    localparam int COUNT_W  = 12;
    localparam int PEAK_W   = 16;
    localparam int VEL_W    = 7;
    localparam int STATUS_W = 8;
    localparam int IDX_W    = 2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [IDX_W-1:0] REG_WINDOW    = 2'd1;
    localparam logic [IDX_W-1:0] REG_DEBOUNCE  = 2'd2;

    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 15'd6554;
    localparam logic [COUNT_W-1:0]  WINDOW_RESET    = 12'd1000;
    localparam logic [COUNT_W-1:0]  DEBOUNCE_RESET  = 12'd2500;

    localparam logic [STATUS_W-1:0] NOTE_ON_STATUS = 8'h9A;
    localparam logic [KEY_W-1:0]    SCALED_KEY     = 3'd4;
    localparam logic [VEL_W-1:0]    VEL_MAX        = 7'd127;

    typedef struct packed {
        logic [THRESH_W-1:0] threshold;
        logic [COUNT_W-1:0]  window;
        logic [COUNT_W-1:0]  debounce;
    } cfg_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [PEAK_W-1:0] peak;
    } job_t;

    typedef struct packed {
        logic [KEY_W-1:0] note;
        logic [VEL_W-1:0] velocity;
    } result_t;

endpackage

`default_nettype wire

// ----- design/piezo_strike_velocity_detector.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel    ports                                   handshake
// input      key, sample                             push / full
// result     status_byte, note, velocity             pop / empty
// config     wr_index, wr_data                       wr_en, no wait
//
// The front takes one item per cycle and updates that key's state in the
// same cycle; it stalls (full) only while the note job queue is full.
// A note-on goes through the velocity unit's prep, scale and check states and,
// unless it is zero or saturates, a 7-step restoring divide; results wait in
// a two-entry output queue. Reset puts every key in wait with zero counter
// and peak, and loads the register defaults. No clearing pass.

module piezo_strike_velocity_detector #(
    parameter int KEY_COUNT = 8,
    parameter int JOB_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   push,
    output logic                                  full,
    input  wire  [psvd_pkg::KEY_W-1:0]            key,
    input  wire  signed [psvd_pkg::SAMPLE_W-1:0]  sample,
    output logic                                  empty,
    input  wire                                   pop,
    output logic [psvd_pkg::STATUS_W-1:0]         status_byte,
    output logic [psvd_pkg::KEY_W-1:0]            note,
    output logic [psvd_pkg::VEL_W-1:0]            velocity,
    input  wire                                   wr_en,
    input  wire  [psvd_pkg::IDX_W-1:0]            wr_index,
    input  wire  [psvd_pkg::THRESH_W-1:0]         wr_data
);

    psvd_pkg::cfg_t     cfg_reg;
    psvd_pkg::job_t     job_in;
    psvd_pkg::job_t     job_out;
    psvd_pkg::result_t  res_in;
    psvd_pkg::result_t  res_out;
    logic               accept;
    logic               job_push;
    logic               job_full;
    logic               job_empty;
    logic               job_pop;
    logic               res_push;
    logic               res_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold <= psvd_pkg::THRESHOLD_RESET;
            cfg_reg.window    <= psvd_pkg::WINDOW_RESET;
            cfg_reg.debounce  <= psvd_pkg::DEBOUNCE_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                psvd_pkg::REG_THRESHOLD: cfg_reg.threshold <= wr_data;
                psvd_pkg::REG_WINDOW:    cfg_reg.window    <= wr_data[psvd_pkg::COUNT_W-1:0];
                psvd_pkg::REG_DEBOUNCE:  cfg_reg.debounce  <= wr_data[psvd_pkg::COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign full   = job_full;
    assign accept = push && !full;

    psvd_front #(
        .KEY_COUNT (KEY_COUNT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .key      (key),
        .sample   (sample),
        .cfg      (cfg_reg),
        .job_push (job_push),
        .job      (job_in)
    );

    psvd_fifo #(
        .WIDTH ($bits(psvd_pkg::job_t)),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (job_full),
        .pop       (job_pop),
        .pop_data  (job_out),
        .empty     (job_empty)
    );

    psvd_velocity u_velocity (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (cfg_reg.threshold),
        .job_valid (!job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    psvd_fifo #(
        .WIDTH ($bits(psvd_pkg::result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_in),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (res_out),
        .empty     (empty)
    );

    assign status_byte = psvd_pkg::NOTE_ON_STATUS;
    assign note        = res_out.note;
    assign velocity    = res_out.velocity;

    job_space: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !job_full)
        else $error("note job issued with the job queue full");

endmodule

`default_nettype wire

// ----- design/psvd_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module psvd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  wire  [WIDTH-1:0] push_data,
    output logic             full,
    input  wire              pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = data_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fifo count beyond depth");

    push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (push && full && !pop) |=> (count_reg == $past(count_reg)))
        else $error("fifo took an item while full");

endmodule

`default_nettype wire

// ----- design/psvd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module psvd_front #(
    parameter int KEY_COUNT = 8
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               accept,
    input  wire  [psvd_pkg::KEY_W-1:0]        key,
    input  wire  signed [psvd_pkg::SAMPLE_W-1:0] sample,
    input  psvd_pkg::cfg_t                    cfg,
    output logic                              job_push,
    output psvd_pkg::job_t                    job
);

    // only eight keys are addressable through the key field
    localparam int KEYS = (KEY_COUNT < 8) ? KEY_COUNT : 8;

    localparam logic [1:0] PH_WAIT     = 2'd0;
    localparam logic [1:0] PH_PEAK     = 2'd1;
    localparam logic [1:0] PH_EMIT     = 2'd2;
    localparam logic [1:0] PH_DEBOUNCE = 2'd3;

    logic [1:0]                     phase_reg [KEYS];
    logic [psvd_pkg::COUNT_W-1:0]   cnt_reg   [KEYS];
    logic [psvd_pkg::PEAK_W-1:0]    peak_reg  [KEYS];

    logic [KEYS-1:0]                hit;
    logic                           in_range;
    logic [1:0]                     cur_phase;
    logic [psvd_pkg::COUNT_W-1:0]   cur_cnt;
    logic [psvd_pkg::PEAK_W-1:0]    cur_peak;
    logic [1:0]                     phase_next;
    logic [psvd_pkg::COUNT_W-1:0]   cnt_next;
    logic [psvd_pkg::PEAK_W-1:0]    peak_next;
    logic [psvd_pkg::PEAK_W-1:0]    mag;
    logic [psvd_pkg::COUNT_W:0]     cnt_inc;
    logic                           update;

    // -32768 rectifies to 0x8000, held as unsigned 32768
    assign mag = sample[psvd_pkg::SAMPLE_W-1] ? (~sample + 16'd1) : sample;

    always_comb
    begin
        cur_phase = '0;
        cur_cnt   = '0;
        cur_peak  = '0;
        for (int k = 0; k < KEYS; k++)
        begin
            hit[k] = (key == 3'(k));
            if (hit[k])
            begin
                cur_phase = cur_phase | phase_reg[k];
                cur_cnt   = cur_cnt   | cnt_reg[k];
                cur_peak  = cur_peak  | peak_reg[k];
            end
        end
    end

    assign in_range = |hit;
    assign update   = accept && in_range;
    assign cnt_inc  = {1'b0, cur_cnt} + 13'd1;

    always_comb
    begin
        phase_next = cur_phase;
        cnt_next   = cur_cnt;
        peak_next  = cur_peak;
        case (cur_phase)
            PH_WAIT:
            begin
                if (mag > {1'b0, cfg.threshold})
                begin
                    phase_next = PH_PEAK;
                end
            end
            PH_PEAK:
            begin
                if (cnt_inc < {1'b0, cfg.window})
                begin
                    cnt_next = cnt_inc[psvd_pkg::COUNT_W-1:0];
                    if (cur_peak <= mag)
                    begin
                        peak_next = mag;
                    end
                end
                else
                begin
                    cnt_next   = '0;
                    phase_next = PH_EMIT;
                end
            end
            PH_EMIT:
            begin
                phase_next = PH_DEBOUNCE;
            end
            default:
            begin
                peak_next = '0;
                if (cnt_inc > {1'b0, cfg.debounce})
                begin
                    cnt_next   = '0;
                    phase_next = PH_WAIT;
                end
                else
                begin
                    cnt_next = cnt_inc[psvd_pkg::COUNT_W-1:0];
                end
            end
        endcase
    end

    assign job_push = update && (cur_phase == PH_EMIT);
    assign job.key  = key;
    assign job.peak = cur_peak;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < KEYS; k++)
            begin
                phase_reg[k] <= PH_WAIT;
                cnt_reg[k]   <= '0;
                peak_reg[k]  <= '0;
            end
        end
        else if (update)
        begin
            for (int k = 0; k < KEYS; k++)
            begin
                if (hit[k])
                begin
                    phase_reg[k] <= phase_next;
                    cnt_reg[k]   <= cnt_next;
                    peak_reg[k]  <= peak_next;
                end
            end
        end
    end

    peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> (job.peak <= 16'h8000))
        else $error("held peak above unity");

endmodule

`default_nettype wire

// ----- design/psvd_velocity.sv -----
`timescale 1ns / 1ps
`default_nettype none

module psvd_velocity (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire  [psvd_pkg::THRESH_W-1:0] threshold,
    input  wire                          job_valid,
    input  psvd_pkg::job_t               job,
    output logic                         job_pop,
    input  wire                          res_full,
    output logic                         res_push,
    output psvd_pkg::result_t            res
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_SCALE = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]                    state_reg;
    logic [psvd_pkg::KEY_W-1:0]    key_reg;
    logic [psvd_pkg::PEAK_W-1:0]   peak_reg;
    logic [18:0]                   a_reg;      // peak * 10, or * 9 for the scaled key
    logic [18:0]                   tt_reg;     // threshold * 10
    logic [18:0]                   d_reg;      // (1.0 - threshold) * 10
    logic signed [27:0]            val_reg;
    logic [26:0]                   rem_reg;
    logic [2:0]                    step_reg;
    logic [psvd_pkg::VEL_W-1:0]    q_reg;

    logic [18:0]                   peak_x;
    logic [18:0]                   thr_x;
    logic signed [27:0]            diff_x;
    logic signed [27:0]            d_x;
    logic [26:0]                   d_top;
    logic [26:0]                   d_step;

    assign peak_x = {3'b0, peak_reg};
    assign thr_x  = {4'b0, threshold};
    assign diff_x = 28'($signed({9'b0, a_reg}) - $signed({9'b0, tt_reg}));
    assign d_x    = $signed({9'b0, d_reg});
    assign d_top  = {1'b0, d_reg, 7'b0};
    assign d_step = {8'b0, d_reg} << step_reg;

    assign job_pop      = (state_reg == ST_IDLE) && job_valid;
    assign res_push     = (state_reg == ST_DONE) && !res_full;
    assign res.note     = key_reg;
    assign res.velocity = q_reg;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                key_reg  <= job.key;
                peak_reg <= job.peak;
            end
            ST_PREP:
            begin
                a_reg  <= (key_reg == psvd_pkg::SCALED_KEY) ? (peak_x << 3) + peak_x
                                                           : (peak_x << 3) + (peak_x << 1);
                tt_reg <= (thr_x << 3) + (thr_x << 1);
                d_reg  <= 19'((20'd32768 - {5'b0, threshold}) * 20'd10);
            end
            ST_SCALE:
            begin
                val_reg <= diff_x * 28'sd107 + d_x * 28'sd20;
            end
            ST_CHECK:
            begin
                rem_reg <= val_reg[26:0];
                if ((val_reg > 28'sd0) && (val_reg[26:0] >= d_top))
                begin
                    q_reg <= psvd_pkg::VEL_MAX;
                end
                else
                begin
                    q_reg <= '0;
                end
            end
            ST_DIV:
            begin
                if (rem_reg >= d_step)
                begin
                    rem_reg           <= rem_reg - d_step;
                    q_reg[step_reg]   <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    step_reg <= 3'd6;
                    if ((val_reg <= 28'sd0) || (val_reg[26:0] >= d_top))
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (step_reg == '0)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        step_reg <= step_reg - 3'd1;
                    end
                end
                ST_DONE:
                begin
                    if (!res_full)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // partial remainder stays below twice the current divisor step
    rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < (d_step << 1)))
        else $error("divide remainder out of range");

endmodule

`default_nettype wire

// ----- tb/piezo_strike_velocity_detector_tb.sv -----
`timescale 1ns / 1ps

module piezo_strike_velocity_detector_tb;

    localparam int           VEL_FLOOR  = 20;
    localparam int           VEL_SPAN   = 107;
    localparam longint       UNITY_Q15  = 32768;
    localparam int           HOLD_LONG  = 400;
    localparam int           IDLE_LIMIT = 5000;
    localparam int           SETTLE     = 20;
    localparam logic [psvd_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {KEY_WAIT, KEY_PEAK, KEY_EMIT, KEY_DEBOUNCE} key_phase_t;

    typedef struct {
        logic [psvd_pkg::KEY_W-1:0]           key;
        logic signed [psvd_pkg::SAMPLE_W-1:0] sample;
    } pad_hit_t;

    typedef struct {
        logic [psvd_pkg::STATUS_W-1:0] status;
        logic [psvd_pkg::KEY_W-1:0]    note;
        logic [psvd_pkg::VEL_W-1:0]    velocity;
    } note_on_t;

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   push = 1'b0;
    logic                                   full;
    logic [psvd_pkg::KEY_W-1:0]             key = '0;
    logic signed [psvd_pkg::SAMPLE_W-1:0]   sample = '0;
    logic                                   empty;
    logic                                   pop = 1'b0;
    logic [psvd_pkg::STATUS_W-1:0]          status_byte;
    logic [psvd_pkg::KEY_W-1:0]             note;
    logic [psvd_pkg::VEL_W-1:0]             velocity;
    logic                                   wr_en = 1'b0;
    logic [psvd_pkg::IDX_W-1:0]             wr_index = '0;
    logic [psvd_pkg::THRESH_W-1:0]          wr_data = '0;

    pad_hit_t pad_hits[$];
    note_on_t expected_notes[$];

    // shadow of the block's registers and per-key machines
    logic [psvd_pkg::THRESH_W-1:0] cfg_threshold = psvd_pkg::THRESHOLD_RESET;
    logic [psvd_pkg::COUNT_W-1:0]  cfg_window    = psvd_pkg::WINDOW_RESET;
    logic [psvd_pkg::COUNT_W-1:0]  cfg_debounce  = psvd_pkg::DEBOUNCE_RESET;
    key_phase_t                    key_state[8];
    logic [psvd_pkg::COUNT_W-1:0]  key_count[8];
    logic [psvd_pkg::PEAK_W-1:0]   key_peak[8];

    int  failures = 0;
    int  notes_predicted = 0;
    int  idle_cycles = 0;
    bit  running = 1'b0;
    bit  no_idle = 1'b0;
    bit  long_hold_req = 1'b0;
    int  send_gap = 0;
    int  hold_left = 0;

    piezo_strike_velocity_detector dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .key         (key),
        .sample      (sample),
        .empty       (empty),
        .pop         (pop),
        .status_byte (status_byte),
        .note        (note),
        .velocity    (velocity),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [psvd_pkg::VEL_W-1:0] strike_velocity(
        input logic [psvd_pkg::KEY_W-1:0] k,
        input logic [psvd_pkg::PEAK_W-1:0] p);
        longint t;
        longint a;
        longint d;
        longint v;
        longint q;
        t = longint'(cfg_threshold);
        a = (k == psvd_pkg::SCALED_KEY) ? longint'(p) * 9 : longint'(p) * 10;
        d = (UNITY_Q15 - t) * 10;
        v = (a - t * 10) * VEL_SPAN + VEL_FLOOR * d;
        if (v <= 0)
            return '0;
        q = v / d;
        if (q > longint'(psvd_pkg::VEL_MAX))
            q = longint'(psvd_pkg::VEL_MAX);
        return q[psvd_pkg::VEL_W-1:0];
    endfunction

    task automatic advance_key(input logic [psvd_pkg::KEY_W-1:0] k,
                               input logic signed [psvd_pkg::SAMPLE_W-1:0] s);
        logic [psvd_pkg::SAMPLE_W:0]  mag;
        logic [psvd_pkg::COUNT_W:0]   n;
        note_on_t                     hit;
        mag = s[psvd_pkg::SAMPLE_W-1] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
        case (key_state[k])
            KEY_WAIT:
            begin
                if (mag > cfg_threshold)
                    key_state[k] = KEY_PEAK;
            end
            KEY_PEAK:
            begin
                n = {1'b0, key_count[k]} + 1'b1;
                if (n < cfg_window)
                begin
                    key_count[k] = n[psvd_pkg::COUNT_W-1:0];
                    if (key_peak[k] <= mag)
                        key_peak[k] = mag[psvd_pkg::PEAK_W-1:0];
                end
                else
                begin
                    key_count[k] = '0;
                    key_state[k] = KEY_EMIT;
                end
            end
            KEY_EMIT:
            begin
                hit.status   = psvd_pkg::NOTE_ON_STATUS;
                hit.note     = k;
                hit.velocity = strike_velocity(k, key_peak[k]);
                expected_notes.push_back(hit);
                notes_predicted++;
                key_state[k] = KEY_DEBOUNCE;
            end
            default:
            begin
                key_peak[k] = '0;
                n = {1'b0, key_count[k]} + 1'b1;
                if (n > cfg_debounce)
                begin
                    key_count[k] = '0;
                    key_state[k] = KEY_WAIT;
                end
                else
                    key_count[k] = n[psvd_pkg::COUNT_W-1:0];
            end
        endcase
    endtask

    // driver: offers the oldest pending item, with random gaps
    always @(negedge clk)
    begin
        if (!running)
            push <= 1'b0;
        else if (send_gap > 0)
        begin
            send_gap--;
            push <= 1'b0;
        end
        else if (pad_hits.size() > 0)
        begin
            if (!no_idle && $urandom_range(0, 15) == 0)
            begin
                send_gap = $urandom_range(1, 19) - 1;
                push <= 1'b0;
            end
            else
            begin
                push   <= 1'b1;
                key    <= pad_hits[0].key;
                sample <= pad_hits[0].sample;
            end
        end
        else
            push <= 1'b0;
    end

    // receiver: pops results, with random hold-offs and one long one on request
    always @(negedge clk)
    begin
        if (!running)
            pop <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            hold_left = HOLD_LONG - 1;
            pop <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 15) == 0)
        begin
            hold_left = $urandom_range(1, 19) - 1;
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    // monitor: predict on accepted items, check accepted results
    always @(posedge clk)
    begin
        if (push && !full)
        begin
            advance_key(key, sample);
            void'(pad_hits.pop_front());
        end
        if (pop && !empty)
        begin
            if (expected_notes.size() == 0)
            begin
                $display("%0t: unexpected note-on: status %0h note %0d velocity %0d",
                         $time, status_byte, note, velocity);
                failures++;
            end
            else
            begin
                if (status_byte !== expected_notes[0].status)
                begin
                    $display("%0t: status_byte expected %0h actual %0h",
                             $time, expected_notes[0].status, status_byte);
                    failures++;
                end
                if (note !== expected_notes[0].note)
                begin
                    $display("%0t: note expected %0d actual %0d",
                             $time, expected_notes[0].note, note);
                    failures++;
                end
                if (velocity !== expected_notes[0].velocity)
                begin
                    $display("%0t: velocity expected %0d actual %0d (note %0d)",
                             $time, expected_notes[0].velocity, velocity,
                             expected_notes[0].note);
                    failures++;
                end
                void'(expected_notes.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic signed [psvd_pkg::SAMPLE_W-1:0] random_sample(input int t);
        int m;
        int r;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 2)
        begin
            r = int'($urandom);
            return r[psvd_pkg::SAMPLE_W-1:0];
        end
        if (pick == 7)
        begin
            case ($urandom_range(0, 3))
                0: return 16'sh8000;
                1: return 16'sh7FFF;
                2: return 16'sh0000;
                default: return 16'shFFFF;
            endcase
        end
        if (pick <= 4)
        begin
            m = t + int'($urandom_range(0, 8)) - 4;
            if (m < 0)
                m = 0;
            if (m > 32767)
                m = 32767;
        end
        else if (pick <= 6)
            m = int'($urandom_range(t, 32767));
        else
            m = int'($urandom_range(0, 255));
        r = $urandom_range(0, 1) ? -m : m;
        return r[psvd_pkg::SAMPLE_W-1:0];
    endfunction

    task automatic queue_hit(input int k, input int s);
        pad_hit_t h;
        h.key = k[psvd_pkg::KEY_W-1:0];
        h.sample = s[psvd_pkg::SAMPLE_W-1:0];
        pad_hits.push_back(h);
    endtask

    task automatic queue_random(input int count, input int k_fixed);
        int i;
        for (i = 0; i < count; i++)
            queue_hit((k_fixed < 0) ? int'($urandom_range(0, 7)) : k_fixed,
                      int'(random_sample(int'(cfg_threshold))));
    endtask

    // block is idle once nothing is pending or owed, plus a margin
    task automatic settle();
        while (pad_hits.size() != 0 || expected_notes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_register(input logic [psvd_pkg::IDX_W-1:0] idx, input int data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data[psvd_pkg::THRESH_W-1:0];
        @(posedge clk);
        case (idx)
            psvd_pkg::REG_THRESHOLD: cfg_threshold = data[psvd_pkg::THRESH_W-1:0];
            psvd_pkg::REG_WINDOW:    cfg_window    = data[psvd_pkg::COUNT_W-1:0];
            psvd_pkg::REG_DEBOUNCE:  cfg_debounce  = data[psvd_pkg::COUNT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic configure(input int t, input int w, input int d);
        settle();
        write_register(psvd_pkg::REG_THRESHOLD, t);
        write_register(psvd_pkg::REG_WINDOW, w);
        write_register(psvd_pkg::REG_DEBOUNCE, d);
    endtask

    initial
    begin
        int k;
        for (k = 0; k < 8; k++)
        begin
            key_state[k] = KEY_WAIT;
            key_count[k] = '0;
            key_peak[k]  = '0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        running = 1'b1;

        // defaults: threshold edge, both rectification extremes, no notes yet
        queue_hit(0, 0);
        queue_hit(0, 6554);
        queue_hit(0, 6555);
        queue_hit(0, 32767);
        queue_hit(0, -32768);
        queue_hit(1, -6554);
        queue_hit(1, -6555);
        queue_hit(7, -1);
        queue_hit(7, 1);

        // top threshold, zero window, zero debounce
        configure(32767, 0, 0);
        queue_hit(3, 32767);
        queue_hit(3, -32768);
        queue_hit(3, 100);
        queue_hit(3, 5);            // note with zero peak: velocity floors at 0
        queue_hit(3, 5);
        queue_hit(0, 0);
        queue_hit(0, 0);            // held full-scale peak reaches velocity 127

        // zero threshold, scaled key catches the most negative sample
        configure(0, 3, 1);
        write_register(REG_UNUSED, 15'h7FFF);
        queue_hit(6, 0);
        queue_hit(4, 1);
        queue_hit(4, -32768);
        queue_hit(4, 7);
        queue_hit(4, 0);
        queue_hit(4, 0);

        configure(6554, 8, 12);
        queue_random(240, -1);
        configure(0, 1, 0);
        queue_random(240, -1);
        configure($urandom_range(2000, 20000), 2, 1);
        queue_random(240, -1);
        long_hold_req = 1'b1;       // block must fill and stall its input
        configure(32767, 5, 3);
        queue_random(240, -1);
        configure($urandom_range(1000, 20000), $urandom_range(1, 16), $urandom_range(0, 24));
        queue_random(240, -1);

        // longer window and debounce on one key
        configure(3000, 40, 50);
        queue_hit(2, 20000);
        queue_random(100, 2);

        configure($urandom_range(1000, 20000), $urandom_range(1, 12), $urandom_range(0, 12));
        no_idle = 1'b1;
        queue_random(240, -1);
        settle();
        while (notes_predicted < 60)
        begin
            queue_random(50, -1);
            settle();
        end

        repeat (40) @(posedge clk);
        if (expected_notes.size() != 0)
        begin
            $display("%0t: %0d note-ons never arrived", $time, expected_notes.size());
            failures++;
        end
        if (failures == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- piezo_strike_velocity_detector.f -----
design/psvd_pkg.sv
design/psvd_fifo.sv
design/psvd_front.sv
design/psvd_velocity.sv
design/piezo_strike_velocity_detector.sv
tb/piezo_strike_velocity_detector_tb.sv
